// File: rtl/core/chme_pkg.sv
// shared types and constants of the chained hash map engine
package chme_pkg;

    typedef enum logic [1:0] {
        OP_GET    = 2'd0,
        OP_SET    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_ABSENT = 2'd1,
        ST_FULL   = 2'd2
    } status_t;

    localparam int COUNT_BITS = 9;

    // controller to datapath commands
    typedef struct packed {
        logic load;        // capture the input transaction
        logic head_latch;  // take the bucket head as first entry of the walk
        logic walk_step;   // advance to the linked entry
        logic hit;         // current entry holds the key
        logic do_get;
        logic do_replace;
        logic do_insert;
        logic free_latch;  // take the successor of the used free entry
        logic do_unlink;
        logic unlink_fix;  // relink the predecessor of a removed entry
        logic mark_absent;
        logic set_full;
        logic clr_start;
        logic clr_step;    // clear one bucket in both head RAMs and thread one free link
        logic grow_start;
        logic grow_scan;   // read and empty the head of the scan bucket
        logic grow_latch;  // take the scanned head as first entry to move
        logic grow_next_bucket;
        logic grow_rd;     // read key and link of the entry to move
        logic grow_look;   // read the new chain head of that entry
        logic grow_move;   // relink the entry into the new chain
        logic grow_finish;
        logic out_load;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic     cur_nil;
        logic     key_match;
        logic     found;
        logic     prev_nil;
        logic     val_zero;
        logic     free_nil;
        logic     need_grow;
        logic     clr_done;
        logic     scan_done;
        logic     gcur_nil;
        op_t      op;
    } stat_t;

endpackage

// File: rtl/core/chme_ram.sv
// generic single port RAM with registered read
module chme_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// File: rtl/core/chme_ctrl.sv
// controller state machine of the chained hash map engine
module chme_ctrl
    import chme_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_fire,
    input  logic  out_busy,
    output logic  in_ready,
    output cmd_t  cmd,
    input  stat_t st
);

    typedef enum logic [3:0] {
        S_BOOT,
        S_IDLE,
        S_HEAD,
        S_HEAD_W,
        S_RD,
        S_CMP,
        S_ACT,
        S_INS,
        S_FIX,
        S_CLR,
        S_GSCAN,
        S_GSCAN_W,
        S_GRD,
        S_GRD_W,
        S_GMOVE,
        S_OUT
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = (state_reg == S_IDLE);
        unique case (state_reg)
            S_BOOT:
            begin
                cmd.clr_step = 1'b1;
                if (st.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_HEAD;
                end
            end
            S_HEAD:
            begin
                if (st.op == OP_CLEAR)
                begin
                    cmd.clr_start = 1'b1;
                    state_next    = S_CLR;
                end
                else
                begin
                    state_next = S_HEAD_W;
                end
            end
            S_HEAD_W:
            begin
                cmd.head_latch = 1'b1;
                state_next     = S_RD;
            end
            S_RD:
            begin
                state_next = st.cur_nil ? S_ACT : S_CMP;
            end
            S_CMP:
            begin
                if (st.key_match)
                begin
                    cmd.hit    = 1'b1;
                    state_next = S_ACT;
                end
                else
                begin
                    cmd.walk_step = 1'b1;
                    state_next    = S_RD;
                end
            end
            S_ACT:
            begin
                state_next = S_OUT;
                unique case (st.op)
                    OP_GET:
                    begin
                        cmd.do_get = 1'b1;
                    end
                    OP_SET:
                    begin
                        if (st.found)
                        begin
                            cmd.do_replace = 1'b1;
                        end
                        else if (st.val_zero)
                        begin
                            cmd.mark_absent = 1'b1;
                        end
                        else if (st.free_nil)
                        begin
                            cmd.set_full = 1'b1;
                        end
                        else
                        begin
                            cmd.do_insert = 1'b1;
                            state_next    = S_INS;
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (st.found)
                        begin
                            cmd.do_unlink = 1'b1;
                            if (!st.prev_nil)
                            begin
                                state_next = S_FIX;
                            end
                        end
                        else
                        begin
                            cmd.mark_absent = 1'b1;
                        end
                    end
                    OP_CLEAR:
                    begin
                        state_next = S_OUT;
                    end
                endcase
            end
            S_INS:
            begin
                cmd.free_latch = 1'b1;
                if (st.need_grow)
                begin
                    cmd.grow_start = 1'b1;
                    state_next     = S_GSCAN;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_FIX:
            begin
                cmd.unlink_fix = 1'b1;
                state_next     = S_OUT;
            end
            S_CLR:
            begin
                cmd.clr_step = 1'b1;
                if (st.clr_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_GSCAN:
            begin
                if (st.scan_done)
                begin
                    cmd.grow_finish = 1'b1;
                    state_next      = S_OUT;
                end
                else
                begin
                    cmd.grow_scan = 1'b1;
                    state_next    = S_GSCAN_W;
                end
            end
            S_GSCAN_W:
            begin
                cmd.grow_latch = 1'b1;
                state_next     = S_GRD;
            end
            S_GRD:
            begin
                if (st.gcur_nil)
                begin
                    cmd.grow_next_bucket = 1'b1;
                    state_next           = S_GSCAN;
                end
                else
                begin
                    cmd.grow_rd = 1'b1;
                    state_next  = S_GRD_W;
                end
            end
            S_GRD_W:
            begin
                cmd.grow_look = 1'b1;
                state_next    = S_GMOVE;
            end
            S_GMOVE:
            begin
                cmd.grow_move = 1'b1;
                state_next    = S_GRD;
            end
            S_OUT:
            begin
                if (!out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_BOOT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/core/chme_dpath.sv
// datapath of the chained hash map engine: memories, walk pointers, result
module chme_dpath
    import chme_pkg::*;
#(
    parameter int ENTRY_POOL   = 256,
    parameter int MAX_BUCKETS  = 256,
    parameter int INITIAL_MASK = 15,
    parameter int KEY_BITS     = 32,
    parameter int VALUE_BITS   = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    output stat_t                 st,
    input  logic [1:0]            in_op,
    input  logic [KEY_BITS-1:0]   in_key,
    input  logic [VALUE_BITS-1:0] in_value,
    output logic [1:0]            res_status,
    output logic                  res_found,
    output logic [VALUE_BITS-1:0] res_value,
    output logic [COUNT_BITS-1:0] res_count
);

    localparam int EB    = $clog2(ENTRY_POOL);
    localparam int PB    = EB + 1;
    localparam int BB    = $clog2(MAX_BUCKETS);
    localparam int NB    = $clog2(ENTRY_POOL + 1);
    localparam int CLR_N = (MAX_BUCKETS > ENTRY_POOL) ? MAX_BUCKETS : ENTRY_POOL;
    localparam int CLB   = $clog2(CLR_N);
    localparam logic [PB-1:0] NIL = PB'(ENTRY_POOL);

    // held transaction
    logic [1:0]            op_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] val_reg;
    // walk state
    logic [PB-1:0] cur_reg, prev_reg, next_reg, head_old_reg, free_reg;
    logic          match_reg;
    logic [BB-1:0] mask_reg;
    logic [NB-1:0] count_reg;
    logic [CLB-1:0] clr_reg;
    // rehash state
    logic [BB:0]   scan_reg;
    logic [PB-1:0] gcur_reg, gnext_reg;
    logic [BB-1:0] gbucket_reg;
    logic          fresh_sel_reg;   // which head RAM is current

    // memory ports
    logic          h_we, f_we, k_we, v_we, l_we;
    logic [BB-1:0] h_addr, f_addr;
    logic [EB-1:0] e_addr, l_addr;
    logic [PB-1:0] h_wdata, f_wdata, l_wdata, h_rdata, f_rdata, l_rdata;
    logic [KEY_BITS-1:0]   k_rdata;
    logic [VALUE_BITS-1:0] v_rdata;

    // current and spare head RAM ports
    logic          cw_we, nw_we;
    logic [BB-1:0] cw_addr, nw_addr;
    logic [PB-1:0] cw_wdata, nw_wdata, cur_head_rd, new_head_rd;

    logic [BB-1:0] key_bucket, new_mask, gkey_bucket;
    logic          clr_bucket_ok, clr_entry_ok;

    assign new_mask      = BB'({mask_reg, 1'b1});
    assign key_bucket    = BB'(key_reg) & mask_reg;
    assign gkey_bucket   = BB'(k_rdata) & new_mask;
    assign clr_bucket_ok = (32'(clr_reg) < 32'(MAX_BUCKETS));
    assign clr_entry_ok  = (32'(clr_reg) < 32'(ENTRY_POOL));

    chme_ram #(.WIDTH(PB), .DEPTH(MAX_BUCKETS)) u_head_a
    (
        .clk(clk), .we(h_we), .addr(h_addr), .wdata(h_wdata), .rdata(h_rdata)
    );
    chme_ram #(.WIDTH(PB), .DEPTH(MAX_BUCKETS)) u_head_b
    (
        .clk(clk), .we(f_we), .addr(f_addr), .wdata(f_wdata), .rdata(f_rdata)
    );
    chme_ram #(.WIDTH(KEY_BITS), .DEPTH(ENTRY_POOL)) u_keys
    (
        .clk(clk), .we(k_we), .addr(e_addr), .wdata(key_reg), .rdata(k_rdata)
    );
    chme_ram #(.WIDTH(VALUE_BITS), .DEPTH(ENTRY_POOL)) u_vals
    (
        .clk(clk), .we(v_we), .addr(e_addr), .wdata(val_reg), .rdata(v_rdata)
    );
    chme_ram #(.WIDTH(PB), .DEPTH(ENTRY_POOL)) u_links
    (
        .clk(clk), .we(l_we), .addr(l_addr), .wdata(l_wdata), .rdata(l_rdata)
    );

    // the two head RAMs swap roles after each rehash
    always_comb
    begin
        if (fresh_sel_reg)
        begin
            f_we = cw_we; f_addr = cw_addr; f_wdata = cw_wdata;
            h_we = nw_we; h_addr = nw_addr; h_wdata = nw_wdata;
            cur_head_rd = f_rdata; new_head_rd = h_rdata;
        end
        else
        begin
            h_we = cw_we; h_addr = cw_addr; h_wdata = cw_wdata;
            f_we = nw_we; f_addr = nw_addr; f_wdata = nw_wdata;
            cur_head_rd = h_rdata; new_head_rd = f_rdata;
        end
    end

    // a write and a read of one address in a cycle return the old contents
    always_comb
    begin
        cw_we = 1'b0; cw_addr = key_bucket;  cw_wdata = NIL;
        nw_we = 1'b0; nw_addr = gbucket_reg; nw_wdata = NIL;
        k_we = 1'b0; v_we = 1'b0; l_we = 1'b0;
        e_addr  = cur_reg[EB-1:0];
        l_addr  = cur_reg[EB-1:0];
        l_wdata = NIL;
        if (cmd.clr_step)
        begin
            cw_we   = clr_bucket_ok; cw_addr = BB'(clr_reg);
            nw_we   = clr_bucket_ok; nw_addr = BB'(clr_reg);
            l_we    = clr_entry_ok;
            l_addr  = EB'(clr_reg);
            l_wdata = PB'(clr_reg) + PB'(1);
        end
        else if (cmd.do_replace)
        begin
            v_we = 1'b1;
        end
        else if (cmd.do_insert)
        begin
            // the link read returns the next free entry
            e_addr  = free_reg[EB-1:0];
            l_addr  = free_reg[EB-1:0];
            k_we = 1'b1; v_we = 1'b1; l_we = 1'b1;
            l_wdata = head_old_reg;
            cw_we   = 1'b1; cw_wdata = free_reg;
        end
        else if (cmd.do_unlink)
        begin
            l_we     = 1'b1; l_wdata = free_reg;
            cw_we    = (prev_reg == NIL);
            cw_wdata = next_reg;
        end
        else if (cmd.unlink_fix)
        begin
            l_we = 1'b1; l_addr = prev_reg[EB-1:0]; l_wdata = next_reg;
        end
        else if (cmd.grow_scan)
        begin
            // old bucket emptied as it is consumed, so the spare RAM stays empty
            cw_we = 1'b1; cw_addr = scan_reg[BB-1:0];
        end
        else if (cmd.grow_rd)
        begin
            e_addr = gcur_reg[EB-1:0];
            l_addr = gcur_reg[EB-1:0];
        end
        else if (cmd.grow_look)
        begin
            nw_addr = gkey_bucket;
        end
        else if (cmd.grow_move)
        begin
            nw_we   = 1'b1; nw_wdata = gcur_reg;
            l_we    = 1'b1; l_addr   = gcur_reg[EB-1:0];
            l_wdata = new_head_rd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg        <= OP_GET;
            key_reg       <= '0;
            val_reg       <= '0;
            cur_reg       <= NIL;
            prev_reg      <= NIL;
            next_reg      <= NIL;
            head_old_reg  <= NIL;
            free_reg      <= '0;
            match_reg     <= 1'b0;
            mask_reg      <= BB'(INITIAL_MASK);
            count_reg     <= '0;
            clr_reg       <= '0;
            scan_reg      <= '0;
            gcur_reg      <= NIL;
            gnext_reg     <= NIL;
            gbucket_reg   <= '0;
            fresh_sel_reg <= 1'b0;
            res_status    <= ST_OK;
            res_found     <= 1'b0;
            res_value     <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                op_reg     <= in_op;
                key_reg    <= in_key;
                val_reg    <= in_value;
                res_status <= ST_OK;
                res_found  <= 1'b0;
                res_value  <= '0;
            end
            if (cmd.head_latch)
            begin
                cur_reg      <= cur_head_rd;
                head_old_reg <= cur_head_rd;
                prev_reg     <= NIL;
                match_reg    <= 1'b0;
            end
            if (cmd.walk_step)
            begin
                prev_reg <= cur_reg;
                cur_reg  <= l_rdata;
            end
            if (cmd.hit)
            begin
                match_reg <= 1'b1;
                next_reg  <= l_rdata;
            end
            if (cmd.do_get)
            begin
                res_found  <= match_reg;
                res_value  <= match_reg ? v_rdata : '0;
                res_status <= match_reg ? ST_OK : ST_ABSENT;
            end
            if (cmd.do_replace)
            begin
                res_found <= 1'b1;
            end
            if (cmd.mark_absent)
            begin
                res_status <= ST_ABSENT;
            end
            if (cmd.set_full)
            begin
                res_status <= ST_FULL;
            end
            if (cmd.do_insert)
            begin
                count_reg <= count_reg + NB'(1);
            end
            if (cmd.free_latch)
            begin
                free_reg <= l_rdata;
            end
            if (cmd.do_unlink)
            begin
                res_found <= 1'b1;
                free_reg  <= cur_reg;
                if (count_reg != '0)
                begin
                    count_reg <= count_reg - NB'(1);
                end
            end
            if (cmd.clr_start)
            begin
                clr_reg   <= '0;
                free_reg  <= '0;
                count_reg <= '0;
            end
            if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + CLB'(1);
            end
            if (cmd.grow_start)
            begin
                scan_reg <= '0;
            end
            if (cmd.grow_latch)
            begin
                gcur_reg <= cur_head_rd;
            end
            if (cmd.grow_next_bucket)
            begin
                scan_reg <= scan_reg + (BB+1)'(1);
            end
            if (cmd.grow_look)
            begin
                gnext_reg   <= l_rdata;
                gbucket_reg <= gkey_bucket;
            end
            if (cmd.grow_move)
            begin
                gcur_reg <= gnext_reg;
            end
            if (cmd.grow_finish)
            begin
                mask_reg      <= new_mask;
                fresh_sel_reg <= !fresh_sel_reg;
            end
        end
    end

    always_comb
    begin
        st.cur_nil   = (cur_reg == NIL);
        st.key_match = (k_rdata == key_reg);
        st.found     = match_reg;
        st.prev_nil  = (prev_reg == NIL);
        st.val_zero  = (val_reg == '0);
        st.free_nil  = (free_reg == NIL);
        st.need_grow = (32'(count_reg) > 32'(mask_reg))
                       && (32'({mask_reg, 1'b1}) < 32'(MAX_BUCKETS));
        st.clr_done  = (clr_reg == CLB'(CLR_N - 1));
        st.scan_done = (scan_reg > {1'b0, mask_reg});
        st.gcur_nil  = (gcur_reg == NIL);
        st.op        = op_t'(op_reg);
    end

    assign res_count = COUNT_BITS'(count_reg);

endmodule

// File: rtl/core/chained_hash_map_engine_core.sv
// Chained hash map engine: a key-value map with separate chaining over a
// fixed entry pool held in single-port RAMs. After reset a clearing pass
// empties the bucket heads and threads the free list; s_tready stays low
// during it. One transaction is in flight at a time and gives exactly one
// result. A get, set or remove goes through S_HEAD and S_HEAD_W, then S_RD
// and S_CMP for each chain entry compared (the entry RAMs have a registered
// read port), then S_ACT and S_OUT; an insertion adds S_INS and a remove
// behind the chain head adds S_FIX. Clear runs the clearing pass in S_CLR,
// and a set that grows the table rehashes, scanning each old bucket through
// S_GSCAN, S_GSCAN_W and S_GRD and moving each entry through S_GRD, S_GRD_W
// and S_GMOVE. A stalled m_tready holds the engine with the result waiting.
module chained_hash_map_engine_core
    import chme_pkg::*;
#(
    parameter int ENTRY_POOL   = 256,
    parameter int MAX_BUCKETS  = 256,
    parameter int INITIAL_MASK = 15,
    parameter int KEY_BITS     = 32,
    parameter int VALUE_BITS   = 32
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // operation, key, value from bit 0 up
    input  logic [((2+KEY_BITS+VALUE_BITS+7)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // status, found, value_out, entry_count from bit 0 up
    output logic [((12+VALUE_BITS+7)/8)*8-1:0] m_tdata
);

    localparam int OW = ((12+VALUE_BITS+7)/8)*8;

    cmd_t  cmd;
    stat_t st;
    logic  in_fire;
    logic  valid_reg;
    logic [1:0]            res_status;
    logic                  res_found;
    logic [VALUE_BITS-1:0] res_value;
    logic [COUNT_BITS-1:0] res_count;
    logic [OW-1:0]         data_reg;

    assign in_fire = s_tvalid && s_tready;

    chme_ctrl u_ctrl
    (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire),
        .out_busy(valid_reg && !m_tready),
        .in_ready(s_tready), .cmd(cmd), .st(st)
    );

    chme_dpath #(
        .ENTRY_POOL(ENTRY_POOL), .MAX_BUCKETS(MAX_BUCKETS),
        .INITIAL_MASK(INITIAL_MASK), .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)
    ) u_dpath
    (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .st(st),
        .in_op(s_tdata[1:0]),
        .in_key(s_tdata[2 +: KEY_BITS]),
        .in_value(s_tdata[2+KEY_BITS +: VALUE_BITS]),
        .res_status(res_status), .res_found(res_found),
        .res_value(res_value), .res_count(res_count)
    );

    // output register decouples the result from the next transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            data_reg  <= '0;
        end
        else
        begin
            if (m_tready)
            begin
                valid_reg <= 1'b0;
            end
            if (cmd.out_load)
            begin
                valid_reg <= 1'b1;
                data_reg  <= OW'({res_count, res_value, res_found, res_status});
            end
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

// File: tb/tb_chained_hash_map_engine_core.sv
// self-checking testbench for the chained hash map engine core
module tb_chained_hash_map_engine_core;
    import chme_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        status_t     status;
        logic        found;
        logic [31:0] value;
        logic [8:0]  count;
    } map_reply_t;

    typedef struct {
        op_t         op;
        logic [31:0] key;
        logic [31:0] value;
        bit          typed;
        map_reply_t  reply;
    } map_row_t;

    localparam int POOL_SIZE  = 256;
    localparam int KEYSET_LEN = 320;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;

    chained_hash_map_engine_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    logic [31:0] map_store [logic [31:0]];
    int unsigned map_held;
    map_reply_t  pending_replies [$];
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned mismatches;
    logic [31:0] keyset [KEYSET_LEN];
    map_row_t    directed_rows [$];

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic map_reply_t apply_map_op(op_t op, logic [31:0] key, logic [31:0] value);
        map_reply_t r;
        r = '{status: ST_OK, found: 1'b0, value: '0, count: '0};
        if (op == OP_CLEAR)
        begin
            map_store.delete();
            map_held = 0;
        end
        else
        begin
            r.found = (map_store.exists(key) != 0);
            case (op)
                OP_GET:
                begin
                    if (r.found)
                        r.value = map_store[key];
                    else
                        r.status = ST_ABSENT;
                end
                OP_SET:
                begin
                    if (r.found)
                        map_store[key] = value;
                    else if (value == '0)
                        r.status = ST_ABSENT;
                    else if (map_held >= POOL_SIZE)
                        r.status = ST_FULL;
                    else
                    begin
                        map_store[key] = value;
                        map_held++;
                    end
                end
                default:
                begin
                    if (r.found)
                    begin
                        map_store.delete(key);
                        map_held--;
                    end
                    else
                        r.status = ST_ABSENT;
                end
            endcase
        end
        r.count = map_held[8:0];
        return r;
    endfunction

    // drives one transaction and records its expected reply once accepted
    task automatic send_op(op_t op, logic [31:0] key, logic [31:0] value, bit typed,
                           map_reply_t typed_reply);
        map_reply_t r;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, value, key, op};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        r = apply_map_op(op, key, value);
        pending_replies.push_back(typed ? typed_reply : r);
    endtask

    task automatic random_op(bit allow_clear);
        int unsigned pick;
        op_t         op;
        logic [31:0] key;
        logic [31:0] value;
        pick  = $urandom_range(99);
        key   = keyset[$urandom_range(KEYSET_LEN - 1)];
        value = ($urandom_range(19) == 0) ? 32'h0 : $urandom;
        if (pick < 1 && allow_clear)
            op = OP_CLEAR;
        else if (pick < 50)
            op = OP_SET;
        else if (pick < 78)
            op = OP_GET;
        else if (pick < 95)
            op = OP_REMOVE;
        else
        begin
            // mostly absent keys spread over the whole key range
            op  = op_t'($urandom_range(2));
            key = $urandom;
        end
        send_op(op, key, value, 1'b0, '0);
    endtask

    task automatic run_phase(int unsigned items, bit fill_first);
        int unsigned n;
        n = 0;
        // distinct keys, low bits give heavy bucket sharing at small masks
        for (int i = 0; i < KEYSET_LEN; i++)
            keyset[i] = ($urandom & 32'hFFFF_FC00) | i;
        if (fill_first)
        begin
            // run the pool past full, then hit the stored keys
            for (int i = 0; i < 262; i++)
                send_op(OP_SET, keyset[i], $urandom | 32'h1, 1'b0, '0);
            n = 262;
        end
        for (; n < items; n++)
            random_op(!fill_first || n > 330);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        map_reply_t exp_r;
        map_reply_t got_r;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
            if (m_tvalid && m_tready)
            begin
                got_r = '{status: status_t'(m_tdata[1:0]), found: m_tdata[2],
                          value: m_tdata[34:3], count: m_tdata[43:35]};
                if (pending_replies.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected reply %p", got_r);
                end
                else
                begin
                    exp_r = pending_replies.pop_front();
                    if (got_r !== exp_r)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("reply mismatch: expected %p got %p", exp_r, got_r);
                    end
                end
            end
        end
    end

    function automatic map_row_t row(op_t op, logic [31:0] key, logic [31:0] value,
                                     bit typed = 1'b0, status_t st = ST_OK,
                                     logic fnd = 1'b0, logic [31:0] vo = '0,
                                     logic [8:0] cnt = '0);
        map_row_t r;
        r.op    = op;
        r.key   = key;
        r.value = value;
        r.typed = typed;
        r.reply = '{status: st, found: fnd, value: vo, count: cnt};
        return r;
    endfunction

    initial
    begin
        #20ms;
        $display("tb_chained_hash_map_engine_core: errors");
        $finish;
    end

    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        map_held       = 0;
        mismatches     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        directed_rows = '{
            row(OP_GET,    32'h0,         32'h0,         1, ST_ABSENT, 0, 0,             0),
            row(OP_REMOVE, 32'hFFFF_FFFF, 32'h0,         1, ST_ABSENT, 0, 0,             0),
            row(OP_SET,    32'h5,         32'h0,         1, ST_ABSENT, 0, 0,             0),
            row(OP_SET,    32'h0,         32'hFFFF_FFFF, 1, ST_OK,     0, 0,             1),
            row(OP_GET,    32'h0,         32'h0,         1, ST_OK,     1, 32'hFFFF_FFFF, 1),
            row(OP_SET,    32'hFFFF_FFFF, 32'h1,         1, ST_OK,     0, 0,             2),
            row(OP_SET,    32'h0000_0010, 32'h8000_0000),
            row(OP_SET,    32'hFFFF_FFF0, 32'h7FFF_FFFF),
            row(OP_GET,    32'h0000_0010, 32'h0),
            row(OP_SET,    32'hFFFF_FFFF, 32'h0,         1, ST_OK,     1, 0,             4),
            row(OP_GET,    32'hFFFF_FFFF, 32'h0,         1, ST_OK,     1, 0,             4),
            row(OP_REMOVE, 32'h0000_0010, 32'h0),
            row(OP_GET,    32'hFFFF_FFF0, 32'h0),
            row(OP_REMOVE, 32'h0,         32'h0),
            row(OP_GET,    32'h0,         32'h0,         1, ST_ABSENT, 0, 0,             2),
            row(OP_SET,    32'h0000_00FF, 32'h1234_5678),
            row(OP_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, ST_OK,     0, 0,             0),
            row(OP_GET,    32'hFFFF_FFFF, 32'h0,         1, ST_ABSENT, 0, 0,             0),
            row(OP_GET,    32'h0000_00FF, 32'h0,         1, ST_ABSENT, 0, 0,             0)
        };
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        foreach (directed_rows[i])
            send_op(directed_rows[i].op, directed_rows[i].key, directed_rows[i].value,
                    directed_rows[i].typed, directed_rows[i].reply);
        send_idle_pct  = 22;
        recv_stall_pct = 55;
        run_phase(450, 1'b1);
        send_idle_pct  = 55;
        recv_stall_pct = 22;
        run_phase(450, 1'b0);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_op(OP_CLEAR, $urandom, $urandom, 1'b0, '0);
        run_phase(450, 1'b1);
        s_tvalid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (50)
            @(posedge clk);
        if (mismatches == 0)
            $display("tb_chained_hash_map_engine_core: clean");
        else
            $display("tb_chained_hash_map_engine_core: errors");
        $finish;
    end

endmodule
